### design/jpd_pkg.sv
// Shared types, constants and the microprogram of the joint PD torque controller.
// No dependencies; every other file of the block but jpd_stream_if refers to it by scoped names.
package jpd_pkg;

  localparam int JOINTS_DEFAULT = 32;
  localparam int IDX_W          = 5;
  localparam int IDX_EXT_W      = 9;   // holds any joint count up to 511
  localparam int GAIN_W         = 31;
  localparam int ALPHA_W        = 16;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 31;
  localparam int STEP_W         = 5;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 16'h8000;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_LIMIT_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELTA_LIMIT       = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]   joint_index;
    logic signed [31:0] pos_desired;
    logic signed [31:0] pos_measured;
    logic signed [31:0] vel_desired;
    logic signed [31:0] vel_measured;
    logic signed [31:0] torque_feedforward;
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_d;
    logic [GAIN_W-1:0]  torque_limit;
    logic [ALPHA_W-1:0] filter_alpha;
    logic               pd_enable;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0]   joint_out;
    logic signed [31:0] torque_command;
    logic               saturated;
  } result_t;

  // One entry of the per-joint state store.
  typedef struct packed {
    logic signed [31:0] filt;
    logic signed [31:0] setpoint;
  } entry_t;

  typedef enum logic [3:0] {
    OP_READ,   // issue the state read
    OP_DIFF,   // latch state, form the setpoint step
    OP_LIMIT,  // clamp the setpoint step
    OP_EP,     // position error into the multiplier operands
    OP_MULH,   // product with the upper half of the operand
    OP_MULL,   // product with the lower half, upper product into the accumulator
    OP_ACC,    // add the lower product
    OP_SHP,    // keep the P term, velocity error into the operands
    OP_SHD,    // add the D term and saturate
    OP_ZEROX,  // PD term is zero
    OP_FDIFF,  // filter difference into the operands
    OP_FILT,   // filter update
    OP_FINAL   // feedforward, torque clamp, state write and result
  } op_t;

  typedef enum logic [1:0] {
    JMP_NONE,
    JMP_ALWAYS,
    JMP_NO_RATE,
    JMP_NO_PD
  } jump_t;

  typedef struct packed {
    op_t               op;
    jump_t             jump;
    logic [STEP_W-1:0] target;
    logic              last;
  } uword_t;

  typedef struct packed {
    logic run;
    op_t  op;
  } ctrl_t;

  typedef struct packed {
    logic rate_off;
    logic pd_off;
  } status_t;

  localparam logic [STEP_W-1:0] LBL_EP    = 5'd3;
  localparam logic [STEP_W-1:0] LBL_ZEROX = 5'd12;
  localparam logic [STEP_W-1:0] LBL_FDIFF = 5'd13;

  function automatic int addr_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic uword_t uw(input op_t op, input jump_t jump,
                                input logic [STEP_W-1:0] target, input logic last);
    uword_t w;
    w.op     = op;
    w.jump   = jump;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  // The microprogram: one control word per step.
  function automatic uword_t rom(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:    w = uw(OP_READ,  JMP_NONE,    '0,        1'b0);
      5'd1:    w = uw(OP_DIFF,  JMP_NO_RATE, LBL_EP,    1'b0);
      5'd2:    w = uw(OP_LIMIT, JMP_NONE,    '0,        1'b0);
      5'd3:    w = uw(OP_EP,    JMP_NO_PD,   LBL_ZEROX, 1'b0);
      5'd4:    w = uw(OP_MULH,  JMP_NONE,    '0,        1'b0);
      5'd5:    w = uw(OP_MULL,  JMP_NONE,    '0,        1'b0);
      5'd6:    w = uw(OP_ACC,   JMP_NONE,    '0,        1'b0);
      5'd7:    w = uw(OP_SHP,   JMP_NONE,    '0,        1'b0);
      5'd8:    w = uw(OP_MULH,  JMP_NONE,    '0,        1'b0);
      5'd9:    w = uw(OP_MULL,  JMP_NONE,    '0,        1'b0);
      5'd10:   w = uw(OP_ACC,   JMP_NONE,    '0,        1'b0);
      5'd11:   w = uw(OP_SHD,   JMP_ALWAYS,  LBL_FDIFF, 1'b0);
      5'd12:   w = uw(OP_ZEROX, JMP_NONE,    '0,        1'b0);
      5'd13:   w = uw(OP_FDIFF, JMP_NONE,    '0,        1'b0);
      5'd14:   w = uw(OP_MULH,  JMP_NONE,    '0,        1'b0);
      5'd15:   w = uw(OP_MULL,  JMP_NONE,    '0,        1'b0);
      5'd16:   w = uw(OP_ACC,   JMP_NONE,    '0,        1'b0);
      5'd17:   w = uw(OP_FILT,  JMP_NONE,    '0,        1'b0);
      default: w = uw(OP_FINAL, JMP_NONE,    '0,        1'b1);
    endcase
    return w;
  endfunction

endpackage

### design/jpd_stream_if.sv
// Valid/ready channel carrying one item of a given payload type.
// Depends on nothing; the payload types come from jpd_pkg where it is instantiated.
interface jpd_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### design/jpd_state_mem.sv
// Per-joint state store: filter output and previous setpoint, one entry per joint.
// Uses jpd_pkg; written bits make entries that were never written read as zero.
module jpd_state_mem #(
  parameter int JOINTS = jpd_pkg::JOINTS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      rd_en,
  input  logic [jpd_pkg::addr_width(JOINTS)-1:0]    rd_addr,
  output jpd_pkg::entry_t                           rd_data,
  input  logic                                      wr_en,
  input  logic [jpd_pkg::addr_width(JOINTS)-1:0]    wr_addr,
  input  jpd_pkg::entry_t                           wr_data
);

  jpd_pkg::entry_t mem [JOINTS];
  logic [JOINTS-1:0] written;
  jpd_pkg::entry_t rd_q;
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      rd_ok <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_ok ? rd_q : '0;

endmodule

### design/jpd_sequencer.sv
// Microcode sequencer: step counter, program table from jpd_pkg and conditional jumps.
// Drives the datapath with one control word per step.
module jpd_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             stall,
  input  jpd_pkg::status_t status,
  output jpd_pkg::ctrl_t   ctrl,
  output logic             ready
);

  logic busy;
  logic [jpd_pkg::STEP_W-1:0] step;
  logic [jpd_pkg::STEP_W-1:0] step_next;
  jpd_pkg::uword_t word;
  logic taken;
  logic finishing;

  assign word = jpd_pkg::rom(step);

  always_comb begin
    unique case (word.jump)
      jpd_pkg::JMP_NONE:    taken = 1'b0;
      jpd_pkg::JMP_ALWAYS:  taken = 1'b1;
      jpd_pkg::JMP_NO_RATE: taken = status.rate_off;
      jpd_pkg::JMP_NO_PD:   taken = status.pd_off;
      default:              taken = 1'b0;
    endcase
  end

  assign step_next = taken ? word.target : step + 1'b1;

  // The last step waits while the previous result has not been taken.
  assign finishing = busy && word.last && !stall;
  assign ctrl.run  = busy && !(word.last && stall);
  assign ctrl.op   = word.op;
  assign ready     = !busy || finishing;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (finishing) begin
      busy <= 1'b0;
    end else if (ctrl.run) begin
      step <= step_next;
    end
  end

endmodule

### design/jpd_datapath.sv
// Datapath of the joint PD controller: item registers, one shared 32x18 multiplier,
// an accumulator and the clamp logic. Uses jpd_pkg; the state store sits beside it.
module jpd_datapath #(
  parameter int JOINTS = jpd_pkg::JOINTS_DEFAULT
) (
  input  logic                                   clk,
  input  jpd_pkg::ctrl_t                         ctrl,
  input  logic                                   load,
  input  jpd_pkg::sample_t                       sample,
  input  logic                                   rate_en,
  input  logic [jpd_pkg::CFG_DATA_W-1:0]         delta_limit,
  output jpd_pkg::status_t                       status,
  output logic                                   rd_en,
  output logic [jpd_pkg::addr_width(JOINTS)-1:0] mem_addr,
  input  jpd_pkg::entry_t                        rd_data,
  output logic                                   wr_en,
  output jpd_pkg::entry_t                        wr_data,
  output jpd_pkg::result_t                       res
);

  localparam int AW = jpd_pkg::addr_width(JOINTS);

  jpd_pkg::sample_t item;
  logic in_range;
  logic signed [31:0] prev, y, x, ynew;
  logic signed [32:0] d;
  logic signed [33:0] pset, mb;
  logic signed [31:0] ma;
  logic signed [49:0] prod;
  logic signed [65:0] acc;
  logic signed [50:0] psum;

  logic [jpd_pkg::IDX_EXT_W-1:0] idx_ext;
  logic signed [31:0] cur_prev, cur_y;
  logic [32:0] d_mag;
  logic signed [33:0] pset_lim;
  logic signed [17:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [65:0] prod_ext;
  logic signed [50:0] pd_sum;
  logic signed [31:0] pd_sat;
  logic signed [50:0] fsum;
  logic [jpd_pkg::ALPHA_W-1:0] alpha_c;
  logic signed [32:0] t;
  logic [32:0] t_mag;
  logic hit;
  logic signed [31:0] torque;

  assign idx_ext  = {{(jpd_pkg::IDX_EXT_W-jpd_pkg::IDX_W){1'b0}}, item.joint_index};
  assign mem_addr = idx_ext[AW-1:0];

  assign status.rate_off = !rate_en;
  assign status.pd_off   = !item.pd_enable;

  // A joint beyond the store works on zero state.
  assign cur_prev = in_range ? rd_data.setpoint : '0;
  assign cur_y    = in_range ? rd_data.filt : '0;

  // Setpoint step clamp; zero counts as positive.
  assign d_mag    = d[32] ? 33'(-d) : 33'(d);
  assign pset_lim = d[32] ? ({{2{prev[31]}}, prev} - {3'b000, delta_limit})
                          : ({{2{prev[31]}}, prev} + {3'b000, delta_limit});

  // The 34-bit operand goes through the multiplier in two 17-bit halves.
  assign mul_b    = (ctrl.op == jpd_pkg::OP_MULH) ? {mb[33], mb[33:17]} : {1'b0, mb[16:0]};
  assign mul_p    = ma * mul_b;
  assign prod_ext = {{16{prod[49]}}, prod};

  assign pd_sum = psum + {acc[65], acc[65:16]};
  assign pd_sat = ((pd_sum[50:31] == '0) || (pd_sum[50:31] == '1)) ? pd_sum[31:0]
                : (pd_sum[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

  assign fsum    = {{19{y[31]}}, y} + acc[65:15];
  assign alpha_c = (item.filter_alpha > jpd_pkg::ALPHA_ONE) ? jpd_pkg::ALPHA_ONE
                                                            : item.filter_alpha;

  // Torque clamp; a magnitude equal to the limit counts as clamped.
  assign t      = {ynew[31], ynew} + {item.torque_feedforward[31], item.torque_feedforward};
  assign t_mag  = t[32] ? 33'(-t) : 33'(t);
  assign hit    = t_mag >= {2'b00, item.torque_limit};
  assign torque = hit ? (t[32] ? -{1'b0, item.torque_limit} : {1'b0, item.torque_limit})
                      : t[31:0];

  assign rd_en   = ctrl.run && (ctrl.op == jpd_pkg::OP_READ);
  assign wr_en   = ctrl.run && (ctrl.op == jpd_pkg::OP_FINAL) && in_range;
  assign wr_data = '{filt: ynew, setpoint: pset[31:0]};

  always_ff @(posedge clk) begin
    if (load) begin
      item     <= sample;
      in_range <= {{(jpd_pkg::IDX_EXT_W-jpd_pkg::IDX_W){1'b0}}, sample.joint_index}
                  < jpd_pkg::IDX_EXT_W'(JOINTS);
    end
    if (ctrl.run) begin
      unique case (ctrl.op)
        jpd_pkg::OP_DIFF: begin
          prev <= cur_prev;
          y    <= cur_y;
          d    <= {item.pos_desired[31], item.pos_desired} - {cur_prev[31], cur_prev};
          pset <= {{2{item.pos_desired[31]}}, item.pos_desired};
        end
        jpd_pkg::OP_LIMIT: begin
          if (d_mag >= {2'b00, delta_limit}) begin
            pset <= pset_lim;
          end
        end
        jpd_pkg::OP_EP: begin
          mb <= pset - {{2{item.pos_measured[31]}}, item.pos_measured};
          ma <= {1'b0, item.gain_p};
        end
        jpd_pkg::OP_MULH: begin
          prod <= mul_p;
        end
        jpd_pkg::OP_MULL: begin
          prod <= mul_p;
          acc  <= prod_ext <<< 17;
        end
        jpd_pkg::OP_ACC: begin
          acc <= acc + prod_ext;
        end
        jpd_pkg::OP_SHP: begin
          psum <= {acc[65], acc[65:16]};
          mb   <= {{2{item.vel_desired[31]}}, item.vel_desired}
                - {{2{item.vel_measured[31]}}, item.vel_measured};
          ma   <= {1'b0, item.gain_d};
        end
        jpd_pkg::OP_SHD: begin
          x <= pd_sat;
        end
        jpd_pkg::OP_ZEROX: begin
          x <= '0;
        end
        jpd_pkg::OP_FDIFF: begin
          mb <= {{2{x[31]}}, x} - {{2{y[31]}}, y};
          ma <= {16'h0000, alpha_c};
        end
        jpd_pkg::OP_FILT: begin
          ynew <= fsum[31:0];
        end
        jpd_pkg::OP_FINAL: begin
          res.joint_out      <= item.joint_index;
          res.torque_command <= torque;
          res.saturated      <= hit;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/joint_pd_torque_control.sv
// Joint PD torque controller: top level with the configuration registers and result register.
// Depends on jpd_pkg, jpd_stream_if, jpd_sequencer, jpd_datapath and jpd_state_mem.
//
// One item is one sample of one joint and gives one result. Items are handled one at a
// time by a short microprogram that runs every product through a single 32x18 multiplier,
// each of the three products (Kp, Kd, filter) in two halves over three steps. With rate
// limiting off the setpoint clamp is skipped, and with PD off both PD products are skipped;
// the next item is accepted in the cycle of the last step. The result waits in an output
// register; if it has not been taken when the next one is ready, the last step holds.
// Filter and setpoint state are zero after reset with no clearing pass, and configuration
// is to be written only while the block is idle; the block itself does not enforce this.
module joint_pd_torque_control #(
  parameter int JOINTS = jpd_pkg::JOINTS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  jpd_stream_if.sink                         sample,
  jpd_stream_if.source                       result,
  input  logic                               cfg_we,
  input  logic [jpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = jpd_pkg::addr_width(JOINTS);

  logic rate_en;
  logic [jpd_pkg::CFG_DATA_W-1:0] delta_limit;
  logic res_valid;
  logic start;
  logic stall;
  logic seq_ready;
  jpd_pkg::ctrl_t   ctrl;
  jpd_pkg::status_t status;
  jpd_pkg::result_t res;
  jpd_pkg::entry_t  rd_data, wr_data;
  logic rd_en, wr_en;
  logic [AW-1:0] mem_addr;

  assign start          = sample.valid && sample.ready;
  assign sample.ready   = seq_ready;
  assign stall          = res_valid && !result.ready;
  assign result.valid   = res_valid;
  assign result.payload = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_en     <= 1'b0;
      delta_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jpd_pkg::REG_RATE_LIMIT_ENABLE: rate_en     <= cfg_data[0];
        jpd_pkg::REG_DELTA_LIMIT:       delta_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctrl.run && (ctrl.op == jpd_pkg::OP_FINAL)) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  jpd_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stall  (stall),
    .status (status),
    .ctrl   (ctrl),
    .ready  (seq_ready)
  );

  jpd_datapath #(.JOINTS(JOINTS)) u_dp (
    .clk         (clk),
    .ctrl        (ctrl),
    .load        (start),
    .sample      (sample.payload),
    .rate_en     (rate_en),
    .delta_limit (delta_limit),
    .status      (status),
    .rd_en       (rd_en),
    .mem_addr    (mem_addr),
    .rd_data     (rd_data),
    .wr_en       (wr_en),
    .wr_data     (wr_data),
    .res         (res)
  );

  jpd_state_mem #(.JOINTS(JOINTS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (mem_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (mem_addr),
    .wr_data (wr_data)
  );

endmodule

### design/jpd_checker.sv
// Port-level checks of the joint PD torque controller, bound to the top level.
// Depends on jpd_pkg and joint_pd_torque_control.
module jpd_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input jpd_pkg::result_t out_payload
);

  // After reset the block is idle, ready for an item and has no result.
  a_reset_idle: assert property (@(posedge clk) rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // Items are worked one at a time: an accepted item blocks the next for a while.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted straight after the first");

  // A result that is not taken stays put.
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("stalled result changed or vanished");

endmodule

bind joint_pd_torque_control jpd_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_payload (result.payload)
);
